### rtl/xoshiro_random_range_generator_top_macros.svh
// assertion macros for the xoshiro random range generator
// depends on nothing; the asserting modules supply clk and arst_n
`ifndef XOSHIRO_RANDOM_RANGE_GENERATOR_TOP_MACROS_SVH
`define XOSHIRO_RANDOM_RANGE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define XRRG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define XRRG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next cycle check failed");
`else
`define XRRG_ASSERT_IMP(label, ante, cons)
`define XRRG_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/xrrg_pkg.sv
// shared types, operation codes and helpers for the xoshiro random range generator
// no dependencies
package xrrg_pkg;

	typedef logic [63:0] word_t;
	typedef logic [1:0]  op_t;

	localparam op_t OP_SEED  = 2'd0;
	localparam op_t OP_FRAC  = 2'd1;
	localparam op_t OP_RAW   = 2'd2;
	localparam op_t OP_RANGE = 2'd3;

	localparam word_t W1_INIT = 64'hff;

	localparam int ROT_MIX   = 7;
	localparam int ROT_S3    = 45;
	localparam int SHL_T     = 17;
	localparam int FRAC_BITS = 53;

	typedef struct packed {
		word_t s0;
		word_t s1;
		word_t s2;
		word_t s3;
	} gen_state_t;

	typedef struct packed {
		gen_state_t nxt;
		word_t      mix;
	} step_res_t;

	// fill every bit below the leading one
	function automatic word_t smear(word_t n);
		word_t m;
		m = n;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		m = m | (m >> 32);
		return m;
	endfunction

endpackage

### rtl/xrrg_step.sv
// one xoshiro256** recurrence step and the first half of the output scrambler
// depends on xrrg_pkg
module xrrg_step (
	input  xrrg_pkg::gen_state_t cur,
	output xrrg_pkg::step_res_t  res
);

	xrrg_pkg::word_t s2x;
	xrrg_pkg::word_t s3x;
	xrrg_pkg::word_t s1x5;

	assign s2x  = cur.s2 ^ cur.s0;
	assign s3x  = cur.s3 ^ cur.s1;
	// times five as shift and add
	assign s1x5 = cur.s1 + (cur.s1 << 2);

	assign res.nxt.s0 = cur.s0 ^ s3x;
	assign res.nxt.s1 = cur.s1 ^ s2x;
	assign res.nxt.s2 = s2x ^ (cur.s1 << xrrg_pkg::SHL_T);
	assign res.nxt.s3 = (s3x << xrrg_pkg::ROT_S3) | (s3x >> (64 - xrrg_pkg::ROT_S3));
	assign res.mix    = (s1x5 << xrrg_pkg::ROT_MIX) | (s1x5 >> (64 - xrrg_pkg::ROT_MIX));

endmodule

### rtl/xoshiro_random_range_generator_top.sv
// xoshiro random range generator: one request in, one result out, one draw at a time
// raw/fraction/range: transfer in, then the step, mix and done states, then the result register
// each range redraw repeats step and mix; seed: WARMUP_STEPS warm-up steps, one step per cycle
// the result register holds a finished result while the next request is taken
// arst_n clears the sequencer and output valid; generator words reset to 0, 0xff, 0, 0
module xoshiro_random_range_generator_top #(
	parameter int WARMUP_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         operation,
	input  logic signed [63:0] arg_a,
	input  logic signed [63:0] arg_b,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [63:0] value,
	output logic               error
);

`include "xoshiro_random_range_generator_top_macros.svh"

	localparam int CW = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WARM = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_MIX  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [CW-1:0]        cnt_q;
	xrrg_pkg::gen_state_t gen_q;
	xrrg_pkg::step_res_t  step_res;
	xrrg_pkg::op_t        op_q;
	xrrg_pkg::word_t      a_q;
	xrrg_pkg::word_t      b_q;
	xrrg_pkg::word_t      n_q;
	logic                 err_q;
	xrrg_pkg::word_t      mix_q;
	xrrg_pkg::word_t      draw_q;
	logic                 out_valid_q;
	xrrg_pkg::word_t      value_q;
	logic                 error_q;

	logic                 in_xfer;
	logic                 out_free;
	xrrg_pkg::word_t      gen_out;
	xrrg_pkg::word_t      masked;
	logic                 redraw;
	xrrg_pkg::word_t      mix_sel;
	xrrg_pkg::word_t      result;
	logic                 result_err;

	xrrg_step u_step (
		.cur (gen_q),
		.res (step_res)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign in_xfer   = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	// second half of the scrambler: times nine as shift and add
	assign gen_out = mix_q + (mix_q << 3);
	assign masked  = gen_out & xrrg_pkg::smear(n_q);
	assign redraw  = (op_q == xrrg_pkg::OP_RANGE) && !err_q && (masked > n_q);

	always_comb begin
		case (op_q)
			xrrg_pkg::OP_FRAC:  mix_sel = gen_out >> (64 - xrrg_pkg::FRAC_BITS);
			xrrg_pkg::OP_RAW:   mix_sel = gen_out;
			xrrg_pkg::OP_RANGE: mix_sel = masked;
			default:            mix_sel = gen_out;
		endcase
	end

	always_comb begin
		result_err = 1'b0;
		case (op_q)
			xrrg_pkg::OP_SEED:  result = a_q;
			xrrg_pkg::OP_RANGE: begin
				result_err = err_q;
				result     = err_q ? '0 : draw_q + a_q;
			end
			default:            result = draw_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			gen_q       <= '{s0: '0, s1: xrrg_pkg::W1_INIT, s2: '0, s3: '0};
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						if (operation == xrrg_pkg::OP_SEED) begin
							gen_q   <= '{s0: arg_a, s1: xrrg_pkg::W1_INIT, s2: arg_b, s3: '0};
							state_q <= (WARMUP_STEPS == 0) ? ST_DONE : ST_WARM;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_WARM: begin
					gen_q <= step_res.nxt;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WARMUP_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_STEP: begin
					gen_q   <= step_res.nxt;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					state_q <= redraw ? ST_STEP : ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q <= operation;
			a_q  <= arg_a;
			b_q  <= arg_b;
		end
		if (state_q == ST_STEP) begin
			mix_q <= step_res.mix;
			n_q   <= b_q - a_q;
			err_q <= $signed(a_q) > $signed(b_q);
		end
		if (state_q == ST_MIX)
			draw_q <= mix_sel;
		if (state_q == ST_DONE && out_free) begin
			value_q <= result;
			error_q <= result_err;
		end
	end

	assign rsp_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	`XRRG_ASSERT_NXT(a_xfer_leaves_idle, in_xfer, state_q != ST_IDLE)
	`XRRG_ASSERT_IMP(a_warm_only_seed, state_q == ST_WARM, op_q == xrrg_pkg::OP_SEED)
	`XRRG_ASSERT_IMP(a_error_zero_value, rsp_valid && error, value_q == '0)
	`XRRG_ASSERT_NXT(a_done_waits, state_q == ST_DONE && !out_free, state_q == ST_DONE)

endmodule
